// ===== sv/rtt_pkg.sv =====
// ----------------------------------------------------------------------------
// rtt_pkg
// Shared types and constants of the repeating timer table.
// ----------------------------------------------------------------------------
package rtt_pkg;

	localparam int SLOTS      = 16;
	localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W      = $clog2(SLOTS + 1);
	localparam int ID_W       = 20;
	localparam int VAL_W      = 16;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 24;

	typedef enum logic [1:0] {
		KIND_TICK   = 2'd0,
		KIND_ADD    = 2'd1,
		KIND_DELETE = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		STAT_FIRED    = 3'd0,
		STAT_ADDED    = 3'd1,
		STAT_REPLACED = 3'd2,
		STAT_FULL     = 3'd3,
		STAT_DELETED  = 3'd4,
		STAT_NOTFOUND = 3'd5,
		STAT_CLEARED  = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]  ident;
		logic [VAL_W-1:0] dly;
		logic [VAL_W-1:0] elapsed;
		logic [VAL_W-1:0] repeats;
	} entry_t;

	typedef struct packed {
		status_t         status;
		logic [ID_W-1:0] id;
		logic            last;
	} result_t;

endpackage

// ===== sv/rtt_result_reg.sv =====
// ----------------------------------------------------------------------------
// rtt_result_reg
// Output holding register for result words on the master stream side.
// ----------------------------------------------------------------------------
module rtt_result_reg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  rtt_pkg::result_t               res,
	output logic                           free,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [rtt_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // result_id, zero pad
	output logic [2:0]                     m_axis_tuser,  // status
	output logic                           m_axis_tlast   // last
);

	logic             vld_q;
	rtt_pkg::result_t res_q;

	assign free = !vld_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (free) begin
			vld_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (free && push) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = vld_q;
	assign m_axis_tdata  = {{(rtt_pkg::OUT_DATA_W - rtt_pkg::ID_W){1'b0}}, res_q.id};
	assign m_axis_tuser  = res_q.status;
	assign m_axis_tlast  = res_q.last;

endmodule

// ===== sv/repeating_timer_table_core.sv =====
// ----------------------------------------------------------------------------
// repeating_timer_table_core
// Ordered table of repeating timers kept in one entry memory; each tick, add
// or delete walks the table with a read-modify-write pass that compacts removed entries.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata (low bit up)                   tuser        tlast
// s_axis    in   timer_id, delay, repeat_count, pad   kind         -
// m_axis    out  result_id, pad                       status       last
//
// Tick, add and delete walk the table once, reading one entry per cycle
// through the single read port of the entry memory unless the walk stalls;
// clear skips the walk. One command is in work at a time. Reset clears
// control state only; entry contents are held in the memory. A held output
// word stalls the walk only when another fired word must go out, and holds
// the final word until the output register frees.
// ----------------------------------------------------------------------------
module repeating_timer_table_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [rtt_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // timer_id, delay, repeat_count, pad
	input  logic [1:0]                     s_axis_tuser,  // kind
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [rtt_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // result_id, pad
	output logic [2:0]                     m_axis_tuser,  // status
	output logic                           m_axis_tlast   // last
);

	localparam int ID_W  = rtt_pkg::ID_W;
	localparam int VAL_W = rtt_pkg::VAL_W;
	localparam int IDX_W = rtt_pkg::IDX_W;
	localparam int CNT_W = rtt_pkg::CNT_W;

	rtt_pkg::state_t state_q, state_d;

	// command word
	rtt_pkg::kind_t   kind_q;
	logic [ID_W-1:0]  id_q;
	logic [VAL_W-1:0] dly_q;
	logic [VAL_W-1:0] rep_q;

	// walk control
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] rd_idx_q, rd_idx_d;
	logic [CNT_W-1:0] w_q, w_d;
	logic             found_q, found_d;
	logic             pend_vld_q, pend_vld_d;
	logic [ID_W-1:0]  pend_id_q;
	logic             pend_load;
	logic             eval_vld_s1;
	logic             stall;

	// entry memory
	rtt_pkg::entry_t mem [rtt_pkg::SLOTS];
	rtt_pkg::entry_t ent_s1;
	rtt_pkg::entry_t mem_wd;
	logic [IDX_W-1:0] mem_wa;
	logic             mem_we;
	logic             rd_en;

	// result path
	logic             push;
	rtt_pkg::result_t push_res;
	logic             out_free;

	logic             accept;
	logic             fire;
	logic             id_hit;
	logic [VAL_W-1:0] rep_dec;

	assign s_axis_tready = (state_q == rtt_pkg::ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign rep_dec = ent_s1.repeats - VAL_W'(1);
	assign id_hit  = !found_q && (ent_s1.ident == id_q);
	assign fire    = eval_vld_s1 && (kind_q == rtt_pkg::KIND_TICK) &&
	                 (ent_s1.elapsed == ent_s1.dly);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rtt_pkg::ST_IDLE;
			count_q     <= '0;
			rd_idx_q    <= '0;
			w_q         <= '0;
			found_q     <= 1'b0;
			pend_vld_q  <= 1'b0;
			eval_vld_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			rd_idx_q   <= rd_idx_d;
			w_q        <= w_d;
			found_q    <= found_d;
			pend_vld_q <= pend_vld_d;
			if (!stall) begin
				eval_vld_s1 <= rd_en;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= rtt_pkg::kind_t'(s_axis_tuser);
			id_q   <= s_axis_tdata[ID_W-1:0];
			dly_q  <= s_axis_tdata[ID_W+VAL_W-1:ID_W];
			rep_q  <= s_axis_tdata[ID_W+2*VAL_W-1:ID_W+VAL_W];
		end
		if (pend_load) begin
			pend_id_q <= ent_s1.ident;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			ent_s1 <= mem[rd_idx_q[IDX_W-1:0]];
		end
	end

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		rd_idx_d   = rd_idx_q;
		w_d        = w_q;
		found_d    = found_q;
		pend_vld_d = pend_vld_q;
		pend_load  = 1'b0;
		stall      = 1'b0;
		rd_en      = 1'b0;
		mem_we     = 1'b0;
		mem_wa     = w_q[IDX_W-1:0];
		mem_wd     = ent_s1;
		push       = 1'b0;
		push_res   = '{status: rtt_pkg::STAT_CLEARED, id: '0, last: 1'b1};

		case (state_q)
			rtt_pkg::ST_IDLE: begin
				if (accept) begin
					rd_idx_d   = '0;
					w_d        = '0;
					found_d    = 1'b0;
					pend_vld_d = 1'b0;
					if (rtt_pkg::kind_t'(s_axis_tuser) == rtt_pkg::KIND_CLEAR) begin
						state_d = rtt_pkg::ST_FINISH;
					end else begin
						state_d = rtt_pkg::ST_WALK;
					end
				end
			end

			rtt_pkg::ST_WALK: begin
				// a second fired word needs room for the one held back
				stall = fire && pend_vld_q && !out_free;
				if (!stall) begin
					if (eval_vld_s1) begin
						mem_we = 1'b1;
						case (kind_q)
							rtt_pkg::KIND_TICK: begin
								if (fire) begin
									mem_wd.elapsed = '0;
									mem_wd.repeats = rep_dec;
									mem_we         = (rep_dec != '0);
									// hold the newest fired id: only the end knows which is last
									pend_load      = 1'b1;
									pend_vld_d     = 1'b1;
									if (pend_vld_q) begin
										push     = 1'b1;
										push_res = '{status: rtt_pkg::STAT_FIRED,
										             id: pend_id_q, last: 1'b0};
									end
								end else begin
									mem_wd.elapsed = ent_s1.elapsed + VAL_W'(1);
								end
							end
							rtt_pkg::KIND_ADD: begin
								if (id_hit) begin
									mem_wd.dly     = dly_q;
									mem_wd.elapsed = '0;
									mem_wd.repeats = rep_q;
									found_d        = 1'b1;
								end
							end
							rtt_pkg::KIND_DELETE: begin
								if (id_hit) begin
									mem_we  = 1'b0;
									found_d = 1'b1;
								end
							end
							default: begin
								mem_we = 1'b0;
							end
						endcase
						if (mem_we) begin
							w_d = w_q + CNT_W'(1);
						end
					end
					if (rd_idx_q < count_q) begin
						rd_en    = 1'b1;
						rd_idx_d = rd_idx_q + CNT_W'(1);
					end else if (!eval_vld_s1) begin
						state_d = rtt_pkg::ST_FINISH;
					end
				end
			end

			rtt_pkg::ST_FINISH: begin
				case (kind_q)
					rtt_pkg::KIND_TICK: begin
						if (!pend_vld_q) begin
							count_d = w_q;
							state_d = rtt_pkg::ST_IDLE;
						end else if (out_free) begin
							push       = 1'b1;
							push_res   = '{status: rtt_pkg::STAT_FIRED,
							               id: pend_id_q, last: 1'b1};
							pend_vld_d = 1'b0;
							count_d    = w_q;
							state_d    = rtt_pkg::ST_IDLE;
						end
					end
					rtt_pkg::KIND_ADD: begin
						if (out_free) begin
							push    = 1'b1;
							state_d = rtt_pkg::ST_IDLE;
							count_d = w_q;
							if (found_q) begin
								push_res = '{status: rtt_pkg::STAT_REPLACED,
								             id: id_q, last: 1'b1};
							end else if (w_q < CNT_W'(rtt_pkg::SLOTS)) begin
								// append behind the last entry
								mem_we   = 1'b1;
								mem_wd   = '{ident: id_q, dly: dly_q,
								             elapsed: '0, repeats: rep_q};
								count_d  = w_q + CNT_W'(1);
								push_res = '{status: rtt_pkg::STAT_ADDED,
								             id: id_q, last: 1'b1};
							end else begin
								push_res = '{status: rtt_pkg::STAT_FULL,
								             id: '0, last: 1'b1};
							end
						end
					end
					rtt_pkg::KIND_DELETE: begin
						if (out_free) begin
							push    = 1'b1;
							count_d = w_q;
							state_d = rtt_pkg::ST_IDLE;
							if (found_q) begin
								push_res = '{status: rtt_pkg::STAT_DELETED,
								             id: id_q, last: 1'b1};
							end else begin
								push_res = '{status: rtt_pkg::STAT_NOTFOUND,
								             id: '0, last: 1'b1};
							end
						end
					end
					default: begin
						if (out_free) begin
							push    = 1'b1;
							count_d = '0;
							state_d = rtt_pkg::ST_IDLE;
						end
					end
				endcase
			end

			default: begin
				state_d = rtt_pkg::ST_IDLE;
			end
		endcase
	end

	rtt_result_reg u_result (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.res           (push_res),
		.free          (out_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ===== sv/rtt_checker.sv =====
// ----------------------------------------------------------------------------
// rtt_checker
// Port-level checks of the repeating timer table, bound to the top level.
// ----------------------------------------------------------------------------
module rtt_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic [rtt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input logic [1:0]                     s_axis_tuser,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [rtt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic [2:0]                     m_axis_tuser,
	input logic                           m_axis_tlast
);

	// one command at a time: busy right after a word is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while a command is in work");

	// only fired words may be followed by more words of the same command
	a_single_word_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != rtt_pkg::STAT_FIRED) |-> m_axis_tlast)
		else $error("non-fired result without last");

	// statuses that carry no timer report id zero
	a_zero_id: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && ((m_axis_tuser == rtt_pkg::STAT_FULL) ||
		                  (m_axis_tuser == rtt_pkg::STAT_NOTFOUND) ||
		                  (m_axis_tuser == rtt_pkg::STAT_CLEARED))
		|-> (m_axis_tdata == '0))
		else $error("id reported on a status without a timer");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
		$stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled result word changed");

endmodule

bind repeating_timer_table_core rtt_checker u_rtt_checker (.*);
